>>> hw/rtl/packet_history_closest_length_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the packet history closest-length unit.
// Each macro takes a label, an antecedent, a consequent and a message.
// ----------------------------------------------------------------------------
`ifndef PACKET_HISTORY_CLOSEST_LENGTH_UNIT_DEFINES_SVH
`define PACKET_HISTORY_CLOSEST_LENGTH_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PHCL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PHCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/phcl_pkg.sv
// ----------------------------------------------------------------------------
// phcl_pkg
// Shared types and codes of the packet history closest-length unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package phcl_pkg;

    // Operation codes of an input item.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    // Status codes of a result item.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_TOO_LONG = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;
    localparam logic [1:0] STAT_NO_MATCH = 2'd3;

    // A length difference at or above this value never matches.
    localparam logic [15:0] NO_MATCH_DIFF = 16'hFFFF;

    // Input item.
    typedef struct packed {
        logic        operation;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] find_length;
    } phcl_in_t;

    // Result item.
    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  slot;
        logic [11:0] packet_length;
    } phcl_out_t;

    // Source of the value loaded into the output register.
    typedef enum logic [1:0] {
        OUT_COMMIT,
        OUT_TOO_LONG,
        OUT_EMPTY,
        OUT_FIND
    } phcl_out_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic           store_byte;
        logic           end_packet;
        logic           commit;
        logic           scan_start;
        logic           scan_step;
        logic           out_load;
        phcl_out_kind_t out_kind;
    } phcl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic too_long;
        logic store_empty;
        logic scan_done;
        logic out_valid;
    } phcl_stat_t;

endpackage

>>> hw/rtl/phcl_datapath.sv
// ----------------------------------------------------------------------------
// phcl_datapath
// Payload areas, length table, order ring, byte counter, search pipeline
// and output register of the packet history closest-length unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phcl_datapath import phcl_pkg::*; #(
    parameter int SLOTS  = 16,
    parameter int BUFLEN = 2048
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  phcl_in_t   s_item,
    input  logic       m_ready,
    input  phcl_cmd_t  cmd,
    output phcl_stat_t stat,
    output logic       m_valid,
    output phcl_out_t  m_item
);

    localparam int AREAS  = SLOTS + 1;
    localparam int AW     = $clog2(AREAS);
    localparam int RW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW     = $clog2(SLOTS + 1);
    localparam int CW1    = CW + 1;
    localparam int LW     = $clog2(BUFLEN + 1);
    localparam int PDEPTH = AREAS * BUFLEN;
    localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;

    // Memories.
    logic [7:0]    pay_mem  [PDEPTH];
    logic [LW-1:0] len_mem  [AREAS];
    logic [AW-1:0] ring_mem [SLOTS];

    // Store bookkeeping.
    logic [RW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] spare_reg, spare_next;
    logic [LW-1:0] bytes_reg, bytes_next;
    logic          ovf_reg, ovf_next;
    logic [LW-1:0] commit_len_reg;

    // Search pipeline.
    logic [RW-1:0] pos_reg;
    logic [CW-1:0] issue_reg;
    logic          s1_reg, s2_reg;
    logic [AW-1:0] ring_rd_reg, area2_reg, best_area_reg;
    logic [LW-1:0] len_rd_reg, best_len_reg;
    logic [15:0]   want_reg, best_diff_reg;
    logic          found_reg;

    // Output register.
    logic          out_valid_reg;
    phcl_out_t     out_reg, out_new;

    logic          full, too_long, issue, better;
    logic [RW-1:0] head_adv, pos_adv, tail_idx, ring_raddr, ring_waddr;
    logic [CW1-1:0] tail_sum, tail_fold;
    logic [PAW-1:0] pay_addr;
    logic [15:0]   len16, diff;

    // Flags and ring arithmetic.
    always_comb begin
        full     = (count_reg == CW'(SLOTS));
        too_long = ovf_reg || (bytes_reg >= LW'(BUFLEN));
        issue    = (issue_reg < count_reg);
        head_adv = (head_reg == RW'(SLOTS - 1)) ? '0 : head_reg + RW'(1);
        pos_adv  = (pos_reg == RW'(SLOTS - 1)) ? '0 : pos_reg + RW'(1);
        tail_sum = CW1'(count_reg) + CW1'(head_reg);
        tail_fold = (tail_sum >= CW1'(SLOTS)) ? tail_sum - CW1'(SLOTS) : tail_sum;
        tail_idx = RW'(tail_fold);
        ring_raddr = cmd.scan_step ? pos_reg : head_reg;
        ring_waddr = full ? head_reg : tail_idx;
        pay_addr = PAW'(spare_reg) * PAW'(BUFLEN) + PAW'(bytes_reg);
    end

    // Distance of the length under test from the request.
    always_comb begin
        len16  = 16'(len_rd_reg);
        diff   = (len16 > want_reg) ? len16 - want_reg : want_reg - len16;
        better = s2_reg && (diff < best_diff_reg);
    end

    // Byte counter and commit of the spare area into the order ring.
    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        spare_next = spare_reg;
        bytes_next = bytes_reg;
        ovf_next   = ovf_reg;
        if (cmd.store_byte) begin
            if (cmd.end_packet) begin
                bytes_next = '0;
                ovf_next   = 1'b0;
            end else if (bytes_reg < LW'(BUFLEN)) begin
                bytes_next = bytes_reg + LW'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.commit) begin
            if (full) begin
                // The oldest entry is evicted and its area becomes the spare.
                head_next  = head_adv;
                spare_next = ring_rd_reg;
            end else begin
                // Areas fill in order, so the next free area is the old count.
                count_next = count_reg + CW'(1);
                spare_next = AW'(count_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
            spare_reg <= AW'(SLOTS);
            bytes_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            spare_reg <= spare_next;
            bytes_reg <= bytes_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Length of the packet that ends with the accepted byte.
    always_ff @(posedge aclk) begin
        if (cmd.store_byte && cmd.end_packet) begin
            commit_len_reg <= bytes_reg + LW'(1);
        end
    end

    // Payload bytes land in the spare area.
    always_ff @(posedge aclk) begin
        if (cmd.store_byte && (bytes_reg < LW'(BUFLEN))) begin
            pay_mem[pay_addr] <= s_item.data_byte;
        end
    end

    // Order ring: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            ring_mem[ring_waddr] <= spare_reg;
        end
        ring_rd_reg <= ring_mem[ring_raddr];
    end

    // Length table: written on commit, read by the search.
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            len_mem[spare_reg] <= commit_len_reg;
        end
        len_rd_reg <= len_mem[ring_rd_reg];
    end

    // Search pipeline control: ring read, then length read, then compare.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= 1'b0;
            s2_reg <= 1'b0;
        end else begin
            s1_reg <= cmd.scan_step && issue;
            s2_reg <= cmd.scan_step && s1_reg;
        end
    end

    // Search walk and best candidate, oldest entry first.
    always_ff @(posedge aclk) begin
        area2_reg <= ring_rd_reg;
        if (cmd.scan_start) begin
            pos_reg       <= head_reg;
            issue_reg     <= '0;
            want_reg      <= s_item.find_length;
            best_diff_reg <= NO_MATCH_DIFF;
            found_reg     <= 1'b0;
        end else if (cmd.scan_step) begin
            if (issue) begin
                pos_reg   <= pos_adv;
                issue_reg <= issue_reg + CW'(1);
            end
            if (better) begin
                best_diff_reg <= diff;
                best_area_reg <= area2_reg;
                best_len_reg  <= len_rd_reg;
                found_reg     <= 1'b1;
            end
        end
    end

    // Result selection.
    always_comb begin
        out_new = '0;
        case (cmd.out_kind)
            OUT_COMMIT: begin
                out_new.status        = STAT_OK;
                out_new.slot          = 5'(spare_reg);
                out_new.packet_length = 12'(commit_len_reg);
            end
            OUT_TOO_LONG: begin
                out_new.status = STAT_TOO_LONG;
            end
            OUT_EMPTY: begin
                out_new.status = STAT_EMPTY;
            end
            OUT_FIND: begin
                if (found_reg) begin
                    out_new.status        = STAT_OK;
                    out_new.slot          = 5'(best_area_reg);
                    out_new.packet_length = 12'(best_len_reg);
                end else begin
                    out_new.status = STAT_NO_MATCH;
                end
            end
            default: begin
                out_new = '0;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= out_new;
        end
    end

    always_comb begin
        stat.too_long    = too_long;
        stat.store_empty = (count_reg == '0);
        stat.scan_done   = !issue && !s1_reg && !s2_reg;
        stat.out_valid   = out_valid_reg;
        m_valid          = out_valid_reg;
        m_item           = out_reg;
    end

endmodule

>>> hw/rtl/phcl_ctrl.sv
// ----------------------------------------------------------------------------
// phcl_ctrl
// Controller of the packet history closest-length unit: accepts items and
// sequences commit and search in the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phcl_ctrl import phcl_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_operation,
    input  logic       s_last_byte,
    input  logic       m_ready,
    input  phcl_stat_t stat,
    output logic       s_ready,
    output phcl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        CS_IDLE   = 3'b001,
        CS_COMMIT = 3'b010,
        CS_SCAN   = 3'b100
    } phcl_state_t;

    phcl_state_t state_reg, state_next;
    logic        accept;

    // Items are taken only when idle and the output register can take a result.
    always_comb begin
        s_ready = (state_reg == CS_IDLE) && (!stat.out_valid || m_ready);
        accept  = s_valid && s_ready;
    end

    // Next state and datapath commands.
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.out_kind = OUT_COMMIT;
        case (state_reg)
            CS_IDLE: begin
                if (accept) begin
                    if (s_operation == OP_INSERT) begin
                        cmd.store_byte = 1'b1;
                        cmd.end_packet = s_last_byte;
                        if (s_last_byte) begin
                            if (stat.too_long) begin
                                cmd.out_load = 1'b1;
                                cmd.out_kind = OUT_TOO_LONG;
                            end else begin
                                state_next = CS_COMMIT;
                            end
                        end
                    end else if (stat.store_empty) begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = OUT_EMPTY;
                    end else begin
                        cmd.scan_start = 1'b1;
                        state_next     = CS_SCAN;
                    end
                end
            end
            CS_COMMIT: begin
                cmd.commit   = 1'b1;
                cmd.out_load = 1'b1;
                cmd.out_kind = OUT_COMMIT;
                state_next   = CS_IDLE;
            end
            CS_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_FIND;
                    state_next   = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/packet_history_closest_length_unit.sv
// ----------------------------------------------------------------------------
// packet_history_closest_length_unit
// Keeps the most recent SLOTS packets and finds the one of nearest length.
// ----------------------------------------------------------------------------
// An insert item carries one payload byte. The item that carries the last
// byte of a good packet also passes through a commit state, since the commit
// reads the oldest ring entry from the registered order ring before it can be
// evicted. A find is accepted, then walks the order ring one entry per cycle,
// then lets the last entry pass the registered length table read and its
// compare, and then loads the result. A find on an empty store and the last
// byte of an oversized packet load their result as they are accepted. Every
// result sits in an output register, and m_valid rises the cycle after the
// work ends. While a result waits there with m_ready low, no new item is
// accepted. Payload areas hold BUFLEN bytes each; there are SLOTS plus one of
// them.
`timescale 1ns / 1ps

module packet_history_closest_length_unit import phcl_pkg::*; #(
    parameter int SLOTS  = 16,
    parameter int BUFLEN = 2048
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  phcl_in_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output phcl_out_t m_item
);

    phcl_cmd_t  cmd;
    phcl_stat_t stat;

    // Controller.
    phcl_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_item.operation),
        .s_last_byte (s_item.last_byte),
        .m_ready     (m_ready),
        .stat        (stat),
        .s_ready     (s_ready),
        .cmd         (cmd)
    );

    // Datapath.
    phcl_datapath #(
        .SLOTS  (SLOTS),
        .BUFLEN (BUFLEN)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_item  (m_item)
    );

endmodule

>>> hw/rtl/phcl_checker.sv
// ----------------------------------------------------------------------------
// phcl_checker
// Port-level assertions for the packet history closest-length unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packet_history_closest_length_unit_defines.svh"

module phcl_checker import phcl_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input phcl_in_t  s_item,
    input logic      m_valid,
    input logic      m_ready,
    input phcl_out_t m_item
);

    // A stalled result stays put.
    `PHCL_ASSERT_NEXT(a_hold_result, m_valid && !m_ready, m_valid && $stable(m_item), "result changed while stalled")

    // Error results carry no slot and no length.
    `PHCL_ASSERT_SAME(a_error_zero, m_valid && (m_item.status != STAT_OK), (m_item.slot == 5'd0) && (m_item.packet_length == 12'd0), "error result with nonzero fields")

    // The block takes no item while a result waits unclaimed.
    `PHCL_ASSERT_SAME(a_ready_backpressure, s_ready, !m_valid || m_ready, "item taken while output is blocked")

    // A byte in the middle of a packet never produces a result.
    `PHCL_ASSERT_NEXT(a_mid_byte_silent, s_valid && s_ready && (s_item.operation == OP_INSERT) && !s_item.last_byte, !m_valid, "result after a middle byte")

endmodule

bind packet_history_closest_length_unit phcl_checker u_checker (.*);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives packet_history_closest_length_unit with insert and find items over a
// valid/ready stream and checks every result item against a local model of
// the packet history. The run covers empty-store finds, length ties, finds in
// the middle of a packet, and eviction from a full store. Random idling on
// both channels shifts gaps across the work.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import phcl_pkg::*;

    localparam int SLOTS        = 16;
    localparam int BUFLEN       = 2048;
    localparam int AREAS        = SLOTS + 1;
    localparam int RANDOM_ITEMS = 1500;
    localparam int PHASE_ITEMS  = 250;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;

    // Tracks stored packets and predicts the result of every accepted item.
    class closest_length_scoreboard;
        int unsigned area_len[AREAS];
        bit          area_busy[AREAS];
        int unsigned ring[SLOTS];
        int unsigned head;
        int unsigned entries;
        int unsigned spare;
        int unsigned held_bytes;
        bit          overrun;
        phcl_out_t   awaited[$];
        int          errors;

        function new();
            foreach (area_busy[i]) begin
                area_busy[i] = 1'b0;
                area_len[i]  = 0;
            end
            foreach (ring[i]) begin
                ring[i] = 0;
            end
            head       = 0;
            entries    = 0;
            spare      = SLOTS;
            held_bytes = 0;
            overrun    = 1'b0;
            errors     = 0;
        endfunction

        function void push_result(logic [1:0] st, int unsigned area, int unsigned len);
            phcl_out_t r;
            r.status        = st;
            r.slot          = 5'(area);
            r.packet_length = 12'(len);
            awaited.insert(awaited.size(), r);
        endfunction

        // Applies one accepted input item and queues the result it causes.
        function void note_input(phcl_in_t it);
            int unsigned want;
            int unsigned gap;
            int unsigned best;
            int unsigned best_area;
            int unsigned pos;
            int unsigned area;
            int unsigned victim;
            bit          found;
            if (it.operation == OP_INSERT) begin
                // Bytes past BUFLEN are dropped and mark the packet as oversized.
                if (held_bytes < BUFLEN) begin
                    held_bytes++;
                end else begin
                    overrun = 1'b1;
                end
                if (!it.last_byte) begin
                    return;
                end
                if (overrun) begin
                    held_bytes = 0;
                    overrun    = 1'b0;
                    push_result(STAT_TOO_LONG, 0, 0);
                    return;
                end
                // Commit into the spare area, evicting the oldest entry when full.
                area            = spare;
                area_len[area]  = held_bytes;
                area_busy[area] = 1'b1;
                if (entries < SLOTS) begin
                    ring[(head + entries) % SLOTS] = area;
                    entries++;
                    spare = 0;
                    for (int i = AREAS - 1; i >= 0; i--) begin
                        if (!area_busy[i]) begin
                            spare = i;
                        end
                    end
                end else begin
                    victim            = ring[head];
                    ring[head]        = area;
                    head              = (head + 1) % SLOTS;
                    area_busy[victim] = 1'b0;
                    spare             = victim;
                end
                push_result(STAT_OK, area, held_bytes);
                held_bytes = 0;
                return;
            end
            if (entries == 0) begin
                push_result(STAT_EMPTY, 0, 0);
                return;
            end
            // Walk from oldest to newest; a strict compare keeps the older on a tie.
            want      = it.find_length;
            best      = NO_MATCH_DIFF;
            best_area = 0;
            found     = 1'b0;
            pos       = head;
            for (int k = 0; k < entries; k++) begin
                area = ring[pos];
                gap  = (area_len[area] > want) ? area_len[area] - want
                                               : want - area_len[area];
                if (gap < best) begin
                    best      = gap;
                    best_area = area;
                    found     = 1'b1;
                end
                pos = (pos + 1) % SLOTS;
            end
            if (!found) begin
                push_result(STAT_NO_MATCH, 0, 0);
            end else begin
                push_result(STAT_OK, best_area, area_len[best_area]);
            end
        endfunction

        // Compares one accepted result item with the oldest prediction.
        function void check_result(phcl_out_t got);
            phcl_out_t ref_item;
            if (awaited.size() == 0) begin
                $error("unexpected result item: status %0d slot %0d length %0d",
                       got.status, got.slot, got.packet_length);
                errors++;
                return;
            end
            ref_item = awaited[0];
            awaited.delete(0);
            if (got.status !== ref_item.status) begin
                $error("status: expected %0d, got %0d", ref_item.status, got.status);
                errors++;
            end
            if (got.slot !== ref_item.slot) begin
                $error("slot: expected %0d, got %0d", ref_item.slot, got.slot);
                errors++;
            end
            if (got.packet_length !== ref_item.packet_length) begin
                $error("packet_length: expected %0d, got %0d",
                       ref_item.packet_length, got.packet_length);
                errors++;
            end
        endfunction

        function int pending_count();
            return awaited.size();
        endfunction

        function void check_leftover();
            if (awaited.size() != 0) begin
                $error("%0d result items never arrived", awaited.size());
                errors += awaited.size();
            end
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    phcl_in_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    phcl_out_t m_item;

    closest_length_scoreboard board;
    bit idle_on     = 1'b1;
    int items_sent  = 0;
    int quiet       = 0;

    packet_history_closest_length_unit #(
        .SLOTS  (SLOTS),
        .BUFLEN (BUFLEN)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #5 aclk = ~aclk;

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(15, 60);
    endfunction

    // Packet lengths stay small most of the time.
    function automatic int random_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(1, 12);
        end
        if (r < 97) begin
            return $urandom_range(13, 80);
        end
        return $urandom_range(200, 600);
    endfunction

    // Requests mostly near stored lengths, sometimes anywhere in range.
    function automatic logic [15:0] random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 16'($urandom_range(0, 90));
        end
        if (r < 85) begin
            return 16'($urandom_range(0, 65535));
        end
        case ($urandom_range(0, 2))
            0: begin
                return 16'd0;
            end
            1: begin
                return 16'hFFFF;
            end
            default: begin
                return 16'(BUFLEN);
            end
        endcase
    endfunction

    // Offers one item at a falling edge and holds it until accepted.
    task automatic send_item(phcl_in_t it);
        int gap;
        s_item  = it;
        s_valid = 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        items_sent++;
        @(negedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic send_byte(logic [7:0] value, logic last);
        phcl_in_t it;
        it.operation   = OP_INSERT;
        it.data_byte   = value;
        it.last_byte   = last;
        it.find_length = 16'($urandom_range(0, 65535));
        send_item(it);
    endtask

    task automatic send_find(logic [15:0] want);
        phcl_in_t it;
        it.operation   = OP_FIND;
        it.data_byte   = 8'($urandom_range(0, 255));
        it.last_byte   = 1'($urandom_range(0, 1));
        it.find_length = want;
        send_item(it);
    endtask

    // Sends a whole packet, with finds mixed in at the given percentage.
    task automatic send_packet(int len, int find_pct);
        for (int i = 1; i <= len; i++) begin
            if ($urandom_range(0, 99) < find_pct) begin
                send_find(random_request());
            end
            send_byte(8'($urandom_range(0, 255)), i == len);
        end
    endtask

    // Holds the sender off until every predicted result has come back.
    task automatic wait_drained();
        s_valid = 1'b0;
        while (board.pending_count() != 0) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    // The receiver stalls at random.
    initial begin
        int stall;
        stall = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_ready = 1'b0;
                stall--;
            end else begin
                m_ready = 1'b1;
                stall   = pick_gap();
            end
        end
    end

    // Check results, record accepted items and watch for a hang.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                board.check_result(m_item);
            end
            if (s_valid && s_ready) begin
                board.note_input(s_item);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= STALL_LIMIT) begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    initial begin
        int start;
        int len;
        int left;
        bit paused;
        board = new();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty store, extremes, a find inside a packet, a tie.
        send_find(16'd0);
        send_find(16'hFFFF);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_find(16'd1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);
        send_find(16'd0);
        send_find(16'hFFFF);
        send_find(16'd2);
        wait_drained();

        // Random part: mostly whole packets with finds mixed in.
        start  = items_sent;
        paused = 1'b0;
        while (items_sent - start < RANDOM_ITEMS) begin
            idle_on = (((items_sent - start) / PHASE_ITEMS) % 2) == 0;
            if (!paused && (items_sent - start) >= RANDOM_ITEMS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 70) begin
                // The last packet is cut short to keep the run near its item budget.
                len  = random_length();
                left = RANDOM_ITEMS - (items_sent - start);
                if (len > left) begin
                    len = left;
                end
                send_packet(len, 8);
            end else begin
                send_find(random_request());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        board.check_leftover();
        if (board.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/phcl_pkg.sv
hw/rtl/phcl_datapath.sv
hw/rtl/phcl_ctrl.sv
hw/rtl/packet_history_closest_length_unit.sv
hw/rtl/phcl_checker.sv
tb/testbench.sv
